>>> hw/rtl/palr_pkg.sv
package palr_pkg;

  // path limits and default spacing
  localparam int unsigned MaxSamplesPerSeg = 62;
  localparam logic [15:0] SpacingReset     = 16'd3277;
  localparam int unsigned CordicSteps      = 24;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_DEGENERATE = 2'd1,
    STATUS_TOO_LONG   = 2'd2
  } status_e;

  // shared multi-cycle arithmetic unit operations
  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_e;

  // coordinate under interpolation
  typedef enum logic [1:0] {
    COORD_X,
    COORD_Y,
    COORD_Z
  } coord_e;

  // far end of the heading chord
  typedef enum logic {
    CHORD_SAMPLE,
    CHORD_VERTEX
  } chord_e;

  // datapath micro-operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LATCH,
    DP_INIT_PATH,
    DP_CLEAR,
    DP_MUL_XX,
    DP_CAP_XX,
    DP_MUL_YY,
    DP_SQRT,
    DP_CAP_LEN,
    DP_MUL_D,
    DP_DIV,
    DP_CAP_Q,
    DP_CORDIC,
    DP_FLUSH_OUT,
    DP_PUSH,
    DP_SEG_END,
    DP_PREV,
    DP_OUT_DEGEN,
    DP_OUT_TOOLONG,
    DP_OUT_LAST
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    coord_e coord;
    chord_e chord;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic abandoned;
    logic in_last;
    logic arith_done;
    logic cordic_done;
    logic len_zero;
    logic too_long;
    logic s_below_len;
    logic pend_valid;
    logic pend_first;
    logic pend_match;
    logic arc_zero;
    logic out_free;
  } dp_sts_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_entry(logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/palr_arith.sv
module palr_arith (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  palr_pkg::arith_op_e       op_i,
  input  logic [67:0]               opa_i,
  input  logic [33:0]               opb_i,
  output logic                      done_o,
  output logic [65:0]               res_o
);

  localparam logic [5:0] MulLast  = 6'd32;
  localparam logic [5:0] DivLast  = 6'd33;
  localparam logic [5:0] SqrtLast = 6'd32;

  logic                busy_q, done_q;
  logic [5:0]          cnt_q;
  palr_pkg::arith_op_e op_q;
  logic [67:0]         sh_q;
  logic [33:0]         b_q;
  logic [65:0]         acc_q;
  logic [36:0]         rem_q;

  // one divide step: shift in a numerator bit, try the divisor
  logic [34:0] div_sh;
  logic        div_ge;
  assign div_sh = {rem_q[33:0], sh_q[67]};
  assign div_ge = div_sh >= {1'b0, b_q};

  // one root step: bring down two radicand bits, try 4r+1
  logic [36:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign sq_sh    = {rem_q[34:0], sh_q[67:66]};
  assign sq_trial = {2'b00, acc_q[32:0], 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= palr_pkg::ARITH_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        unique case (op_i)
          palr_pkg::ARITH_MUL:  cnt_q <= MulLast;
          palr_pkg::ARITH_DIV:  cnt_q <= DivLast;
          palr_pkg::ARITH_SQRT: cnt_q <= SqrtLast;
          default:              cnt_q <= MulLast;
        endcase
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      unique case (op_i)
        palr_pkg::ARITH_MUL: begin
          sh_q  <= {35'd0, opa_i[32:0]};
          b_q   <= {1'b0, opb_i[32:0]};
          rem_q <= '0;
        end
        palr_pkg::ARITH_DIV: begin
          sh_q  <= {opa_i[33:0], 34'd0};
          b_q   <= opb_i;
          rem_q <= {3'd0, opa_i[67:34]};
        end
        palr_pkg::ARITH_SQRT: begin
          sh_q  <= {opa_i[65:0], 2'b00};
          b_q   <= '0;
          rem_q <= '0;
        end
        default: begin
          sh_q  <= '0;
          b_q   <= '0;
          rem_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        palr_pkg::ARITH_MUL: begin
          acc_q <= acc_q + (b_q[0] ? sh_q[65:0] : 66'd0);
          sh_q  <= {sh_q[66:0], 1'b0};
          b_q   <= {1'b0, b_q[33:1]};
        end
        palr_pkg::ARITH_DIV: begin
          rem_q <= {2'b00, (div_ge ? (div_sh - {1'b0, b_q}) : div_sh)};
          acc_q <= {acc_q[64:0], div_ge};
          sh_q  <= {sh_q[66:0], 1'b0};
        end
        palr_pkg::ARITH_SQRT: begin
          rem_q <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          acc_q <= {acc_q[64:0], sq_ge};
          sh_q  <= {sh_q[65:0], 2'b00};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

>>> hw/rtl/palr_cordic.sv
module palr_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dx_i,
  input  logic [32:0] dy_i,
  output logic        done_o,
  output logic [15:0] yaw_o
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_NORM,
    C_ITER,
    C_FOLD
  } cordic_state_e;

  localparam logic [4:0] LastStep = 5'(palr_pkg::CordicSteps - 1);

  cordic_state_e      state_q;
  logic [32:0]        ax_q, ay_q;
  logic signed [33:0] x_q, y_q;
  logic [31:0]        z_q;
  logic [4:0]         it_q;
  logic               negx_q, negy_q, done_q;
  logic [15:0]        yaw_q;

  logic [32:0]        abs_dx, abs_dy, mx;
  logic signed [33:0] xs, ys;
  logic [31:0]        ang, ang_rnd;

  assign abs_dx = dx_i[32] ? (~dx_i + 33'd1) : dx_i;
  assign abs_dy = dy_i[32] ? (~dy_i + 33'd1) : dy_i;
  assign mx     = (ax_q > ay_q) ? ax_q : ay_q;
  assign xs     = x_q >>> it_q;
  assign ys     = y_q >>> it_q;

  // fold the first-quadrant angle into the chord's quadrant
  always_comb begin
    if (negx_q) begin
      ang = negy_q ? (z_q + 32'h8000_0000) : (32'h8000_0000 - z_q);
    end else begin
      ang = negy_q ? (32'd0 - z_q) : z_q;
    end
    ang_rnd = ang + 32'h0000_8000;
  end

  // normalize, then 24 vectoring rotations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      ax_q    <= '0;
      ay_q    <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      it_q    <= '0;
      negx_q  <= 1'b0;
      negy_q  <= 1'b0;
      done_q  <= 1'b0;
      yaw_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            negx_q <= dx_i[32];
            negy_q <= dy_i[32];
            ax_q   <= abs_dx;
            ay_q   <= abs_dy;
            if ((abs_dx == '0) && (abs_dy == '0)) begin
              yaw_q  <= '0;
              done_q <= 1'b1;
            end else begin
              state_q <= C_NORM;
            end
          end
        end
        C_NORM: begin
          if (mx[32:30] != 3'd0) begin
            ax_q <= {1'b0, ax_q[32:1]};
            ay_q <= {1'b0, ay_q[32:1]};
          end else if (!mx[29]) begin
            ax_q <= {ax_q[31:0], 1'b0};
            ay_q <= {ay_q[31:0], 1'b0};
          end else begin
            x_q     <= signed'({1'b0, ax_q});
            y_q     <= signed'({1'b0, ay_q});
            z_q     <= '0;
            it_q    <= '0;
            state_q <= C_ITER;
          end
        end
        C_ITER: begin
          if (!y_q[33]) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + palr_pkg::atan_entry(it_q);
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - palr_pkg::atan_entry(it_q);
          end
          if (it_q == LastStep) begin
            state_q <= C_FOLD;
          end else begin
            it_q <= it_q + 5'd1;
          end
        end
        C_FOLD: begin
          yaw_q   <= ang_rnd[31:16];
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign yaw_o  = yaw_q;

endmodule

>>> hw/rtl/palr_datapath.sv
module palr_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  palr_pkg::dp_cmd_t cmd_i,
  output palr_pkg::dp_sts_t sts_o,
  input  logic [31:0]       in_x_i,
  input  logic [31:0]       in_y_i,
  input  logic [31:0]       in_z_i,
  input  logic [15:0]       in_heading_i,
  input  logic              in_last_i,
  input  logic              cfg_wr_en_i,
  input  logic [15:0]       cfg_wr_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       out_x_o,
  output logic [31:0]       out_y_o,
  output logic [31:0]       out_z_o,
  output logic [15:0]       out_heading_o,
  output logic              out_last_o,
  output logic [1:0]        out_status_o
);

  // configuration and latched vertex
  logic [15:0] spacing_q, sp;
  logic [31:0] in_x_q, in_y_q, in_z_q;
  logic [15:0] in_hd_q;
  logic        in_last_q;

  // path state
  logic        started_q, abandoned_q, pend_valid_q, pend_first_q;
  logic [31:0] prev_x_q, prev_y_q, prev_z_q;
  logic [47:0] arc_q, next_q;
  logic [31:0] pend_x_q, pend_y_q, pend_z_q;
  logic [31:0] eb_x_q, eb_y_q;
  logic [15:0] first_hd_q;

  // segment working registers
  logic [64:0] x2_q;
  logic [32:0] len_q;
  logic [47:0] off_q, s_q;
  logic [31:0] smp_x_q, smp_y_q, smp_z_q;

  // result register
  logic        out_valid_q, out_last_q;
  logic [31:0] out_x_q, out_y_q, out_z_q;
  logic [15:0] out_hd_q;
  logic [1:0]  out_status_q;

  // arithmetic units
  logic                arith_start, arith_done, cordic_start, cordic_done;
  palr_pkg::arith_op_e arith_op;
  logic [67:0]         arith_a;
  logic [33:0]         arith_b;
  logic [65:0]         arith_res;
  logic [32:0]         chord_dx, chord_dy;
  logic [15:0]         cordic_yaw;

  logic [32:0] dx, dy, ax, ay, dc, adc;
  logic [31:0] p0, p1, tx, ty, q32, interp_v;
  logic [65:0] sq_sum;
  logic [48:0] len_minus_off;
  logic [21:0] seg_limit;
  logic        out_free;
  logic        out_load;

  assign sp = (spacing_q == 16'd0) ? 16'd1 : spacing_q;

  // planar deltas of the current segment
  assign dx = {in_x_q[31], in_x_q} - {prev_x_q[31], prev_x_q};
  assign dy = {in_y_q[31], in_y_q} - {prev_y_q[31], prev_y_q};
  assign ax = dx[32] ? (~dx + 33'd1) : dx;
  assign ay = dy[32] ? (~dy + 33'd1) : dy;

  // coordinate under interpolation
  always_comb begin
    unique case (cmd_i.coord)
      palr_pkg::COORD_X: begin p0 = prev_x_q; p1 = in_x_q; end
      palr_pkg::COORD_Y: begin p0 = prev_y_q; p1 = in_y_q; end
      palr_pkg::COORD_Z: begin p0 = prev_z_q; p1 = in_z_q; end
      default:           begin p0 = prev_z_q; p1 = in_z_q; end
    endcase
  end
  assign dc       = {p1[31], p1} - {p0[31], p0};
  assign adc      = dc[32] ? (~dc + 33'd1) : dc;
  assign q32      = arith_res[31:0];
  assign interp_v = dc[32] ? (p0 - q32) : (p0 + q32);

  assign sq_sum = {1'b0, x2_q} + arith_res;

  // arithmetic unit operand selection
  always_comb begin
    arith_start = 1'b0;
    arith_op    = palr_pkg::ARITH_MUL;
    arith_a     = '0;
    arith_b     = '0;
    unique case (cmd_i.op)
      palr_pkg::DP_MUL_XX: begin
        arith_start = 1'b1;
        arith_a     = {35'd0, ax};
        arith_b     = {1'b0, ax};
      end
      palr_pkg::DP_MUL_YY: begin
        arith_start = 1'b1;
        arith_a     = {35'd0, ay};
        arith_b     = {1'b0, ay};
      end
      palr_pkg::DP_MUL_D: begin
        arith_start = 1'b1;
        arith_a     = {35'd0, adc};
        arith_b     = {1'b0, s_q[32:0]};
      end
      palr_pkg::DP_SQRT: begin
        arith_start = 1'b1;
        arith_op    = palr_pkg::ARITH_SQRT;
        arith_a     = {2'b00, sq_sum};
      end
      palr_pkg::DP_DIV: begin
        arith_start = 1'b1;
        arith_op    = palr_pkg::ARITH_DIV;
        arith_a     = {1'b0, arith_res, 1'b0} + {35'd0, len_q};
        arith_b     = {len_q, 1'b0};
      end
      default: begin
        arith_start = 1'b0;
      end
    endcase
  end

  palr_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (arith_start),
    .op_i    (arith_op),
    .opa_i   (arith_a),
    .opb_i   (arith_b),
    .done_o  (arith_done),
    .res_o   (arith_res)
  );

  // heading chord from the last sent sample
  assign tx           = (cmd_i.chord == palr_pkg::CHORD_VERTEX) ? in_x_q : smp_x_q;
  assign ty           = (cmd_i.chord == palr_pkg::CHORD_VERTEX) ? in_y_q : smp_y_q;
  assign chord_dx     = {tx[31], tx} - {eb_x_q[31], eb_x_q};
  assign chord_dy     = {ty[31], ty} - {eb_y_q[31], eb_y_q};
  assign cordic_start = (cmd_i.op == palr_pkg::DP_CORDIC);

  palr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (chord_dx),
    .dy_i    (chord_dy),
    .done_o  (cordic_done),
    .yaw_o   (cordic_yaw)
  );

  // sample count check: too long when len - off exceeds the limit times spacing
  assign len_minus_off = {16'd0, len_q} - {1'b0, off_q};
  assign seg_limit     = 22'(sp) * 22'(palr_pkg::MaxSamplesPerSeg);
  assign out_free      = !out_valid_q || out_ready_i;

  // a new result beat enters the output register
  assign out_load = (cmd_i.op == palr_pkg::DP_FLUSH_OUT) ||
                    (cmd_i.op == palr_pkg::DP_OUT_TOOLONG) ||
                    (cmd_i.op == palr_pkg::DP_OUT_DEGEN) ||
                    (cmd_i.op == palr_pkg::DP_OUT_LAST);

  always_comb begin
    sts_o             = '0;
    sts_o.started     = started_q;
    sts_o.abandoned   = abandoned_q;
    sts_o.in_last     = in_last_q;
    sts_o.arith_done  = arith_done;
    sts_o.cordic_done = cordic_done;
    sts_o.len_zero    = (len_q == '0);
    sts_o.too_long    = ({15'd0, len_q} > off_q) &&
                        (len_minus_off[47:0] > {26'd0, seg_limit});
    sts_o.s_below_len = s_q < {15'd0, len_q};
    sts_o.pend_valid  = pend_valid_q;
    sts_o.pend_first  = pend_first_q;
    sts_o.pend_match  = (pend_x_q == in_x_q) && (pend_y_q == in_y_q);
    sts_o.arc_zero    = (arc_q == '0);
    sts_o.out_free    = out_free;
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= palr_pkg::SpacingReset;
    end else if (cfg_wr_en_i) begin
      spacing_q <= cfg_wr_data_i;
    end
  end

  // path state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      abandoned_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_first_q <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_z_q     <= '0;
      arc_q        <= '0;
      next_q       <= '0;
      pend_x_q     <= '0;
      pend_y_q     <= '0;
      pend_z_q     <= '0;
      eb_x_q       <= '0;
      eb_y_q       <= '0;
      first_hd_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        palr_pkg::DP_INIT_PATH: begin
          started_q    <= 1'b1;
          prev_x_q     <= in_x_q;
          prev_y_q     <= in_y_q;
          prev_z_q     <= in_z_q;
          arc_q        <= '0;
          next_q       <= {32'd0, sp};
          pend_valid_q <= 1'b1;
          pend_x_q     <= in_x_q;
          pend_y_q     <= in_y_q;
          pend_z_q     <= in_z_q;
          pend_first_q <= 1'b1;
          first_hd_q   <= in_hd_q;
        end
        palr_pkg::DP_FLUSH_OUT: begin
          out_valid_q <= 1'b1;
          eb_x_q      <= pend_x_q;
          eb_y_q      <= pend_y_q;
        end
        palr_pkg::DP_PUSH: begin
          pend_valid_q <= 1'b1;
          pend_first_q <= 1'b0;
          pend_x_q     <= smp_x_q;
          pend_y_q     <= smp_y_q;
          pend_z_q     <= smp_z_q;
        end
        palr_pkg::DP_SEG_END: begin
          next_q <= next_q + s_q - off_q;
          arc_q  <= arc_q + {15'd0, len_q};
        end
        palr_pkg::DP_PREV: begin
          prev_x_q <= in_x_q;
          prev_y_q <= in_y_q;
          prev_z_q <= in_z_q;
        end
        palr_pkg::DP_OUT_TOOLONG: begin
          out_valid_q <= 1'b1;
          if (in_last_q) begin
            started_q    <= 1'b0;
            abandoned_q  <= 1'b0;
            pend_valid_q <= 1'b0;
            pend_first_q <= 1'b0;
            arc_q        <= '0;
            next_q       <= '0;
            eb_x_q       <= '0;
            eb_y_q       <= '0;
          end else begin
            abandoned_q <= 1'b1;
          end
        end
        palr_pkg::DP_OUT_DEGEN, palr_pkg::DP_OUT_LAST, palr_pkg::DP_CLEAR: begin
          if (cmd_i.op != palr_pkg::DP_CLEAR) begin
            out_valid_q <= 1'b1;
          end
          started_q    <= 1'b0;
          abandoned_q  <= 1'b0;
          pend_valid_q <= 1'b0;
          pend_first_q <= 1'b0;
          prev_x_q     <= '0;
          prev_y_q     <= '0;
          prev_z_q     <= '0;
          arc_q        <= '0;
          next_q       <= '0;
          pend_x_q     <= '0;
          pend_y_q     <= '0;
          pend_z_q     <= '0;
          eb_x_q       <= '0;
          eb_y_q       <= '0;
          first_hd_q   <= '0;
        end
        default: begin
          started_q <= started_q;
        end
      endcase
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      palr_pkg::DP_LATCH: begin
        in_x_q    <= in_x_i;
        in_y_q    <= in_y_i;
        in_z_q    <= in_z_i;
        in_hd_q   <= in_heading_i;
        in_last_q <= in_last_i;
      end
      palr_pkg::DP_CAP_XX: begin
        x2_q <= arith_res[64:0];
      end
      palr_pkg::DP_CAP_LEN: begin
        len_q <= arith_res[32:0];
        off_q <= next_q - arc_q;
        s_q   <= next_q - arc_q;
      end
      palr_pkg::DP_CAP_Q: begin
        unique case (cmd_i.coord)
          palr_pkg::COORD_X: smp_x_q <= interp_v;
          palr_pkg::COORD_Y: smp_y_q <= interp_v;
          palr_pkg::COORD_Z: smp_z_q <= interp_v;
          default:           smp_z_q <= interp_v;
        endcase
      end
      palr_pkg::DP_PUSH: begin
        s_q <= s_q + {32'd0, sp};
      end
      palr_pkg::DP_FLUSH_OUT: begin
        out_x_q      <= pend_x_q;
        out_y_q      <= pend_y_q;
        out_z_q      <= pend_z_q;
        out_hd_q     <= pend_first_q ? first_hd_q : cordic_yaw;
        out_last_q   <= 1'b0;
        out_status_q <= palr_pkg::STATUS_OK;
      end
      palr_pkg::DP_OUT_LAST: begin
        out_x_q      <= in_x_q;
        out_y_q      <= in_y_q;
        out_z_q      <= in_z_q;
        out_hd_q     <= in_hd_q;
        out_last_q   <= 1'b1;
        out_status_q <= palr_pkg::STATUS_OK;
      end
      palr_pkg::DP_OUT_DEGEN: begin
        out_x_q      <= '0;
        out_y_q      <= '0;
        out_z_q      <= '0;
        out_hd_q     <= '0;
        out_last_q   <= 1'b1;
        out_status_q <= palr_pkg::STATUS_DEGENERATE;
      end
      palr_pkg::DP_OUT_TOOLONG: begin
        out_x_q      <= '0;
        out_y_q      <= '0;
        out_z_q      <= '0;
        out_hd_q     <= '0;
        out_last_q   <= 1'b1;
        out_status_q <= palr_pkg::STATUS_TOO_LONG;
      end
      default: begin
        out_last_q <= out_last_q;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_z_o       = out_z_q;
  assign out_heading_o = out_hd_q;
  assign out_last_o    = out_last_q;
  assign out_status_o  = out_status_q;

endmodule

>>> hw/rtl/palr_ctrl.sv
module palr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  palr_pkg::dp_sts_t sts_i,
  output palr_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_W_XX,
    S_M_YY,
    S_W_YY,
    S_SQRT_GO,
    S_W_SQ,
    S_CHECK,
    S_TOOLONG,
    S_LOOP,
    S_MUL_D,
    S_W_MD,
    S_DIV_GO,
    S_W_DV,
    S_FLUSH_CHK,
    S_COR_GO,
    S_W_COR,
    S_FLUSH_OUT,
    S_PUSH,
    S_SEG_END,
    S_PREV,
    S_LAST_CHK,
    S_LAST_OUT,
    S_DEGEN
  } ctrl_state_e;

  ctrl_state_e      state_q, state_d;
  palr_pkg::coord_e coord_q, coord_d;
  logic             last_phase_q, last_phase_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_d      = state_q;
    coord_d      = coord_q;
    last_phase_d = last_phase_q;
    cmd_o.op     = palr_pkg::DP_NOP;
    cmd_o.coord  = coord_q;
    cmd_o.chord  = last_phase_q ? palr_pkg::CHORD_VERTEX : palr_pkg::CHORD_SAMPLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = palr_pkg::DP_LATCH;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        last_phase_d = 1'b0;
        if (sts_i.abandoned) begin
          if (sts_i.in_last) begin
            cmd_o.op = palr_pkg::DP_CLEAR;
          end
          state_d = S_IDLE;
        end else if (!sts_i.started) begin
          if (sts_i.in_last) begin
            state_d = S_DEGEN;
          end else begin
            cmd_o.op = palr_pkg::DP_INIT_PATH;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = palr_pkg::DP_MUL_XX;
          state_d  = S_W_XX;
        end
      end
      S_W_XX: begin
        if (sts_i.arith_done) begin
          cmd_o.op = palr_pkg::DP_CAP_XX;
          state_d  = S_M_YY;
        end
      end
      S_M_YY: begin
        cmd_o.op = palr_pkg::DP_MUL_YY;
        state_d  = S_W_YY;
      end
      S_W_YY: begin
        if (sts_i.arith_done) begin
          state_d = S_SQRT_GO;
        end
      end
      S_SQRT_GO: begin
        cmd_o.op = palr_pkg::DP_SQRT;
        state_d  = S_W_SQ;
      end
      S_W_SQ: begin
        if (sts_i.arith_done) begin
          cmd_o.op = palr_pkg::DP_CAP_LEN;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.len_zero) begin
          state_d = S_PREV;
        end else if (sts_i.too_long) begin
          state_d = S_TOOLONG;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_TOOLONG: begin
        if (sts_i.out_free) begin
          cmd_o.op = palr_pkg::DP_OUT_TOOLONG;
          state_d  = S_IDLE;
        end
      end
      S_LOOP: begin
        coord_d = palr_pkg::COORD_X;
        state_d = sts_i.s_below_len ? S_MUL_D : S_SEG_END;
      end
      S_MUL_D: begin
        cmd_o.op = palr_pkg::DP_MUL_D;
        state_d  = S_W_MD;
      end
      S_W_MD: begin
        if (sts_i.arith_done) begin
          state_d = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.op = palr_pkg::DP_DIV;
        state_d  = S_W_DV;
      end
      S_W_DV: begin
        if (sts_i.arith_done) begin
          cmd_o.op = palr_pkg::DP_CAP_Q;
          unique case (coord_q)
            palr_pkg::COORD_X: begin coord_d = palr_pkg::COORD_Y; state_d = S_MUL_D; end
            palr_pkg::COORD_Y: begin coord_d = palr_pkg::COORD_Z; state_d = S_MUL_D; end
            default:           state_d = S_FLUSH_CHK;
          endcase
        end
      end
      S_FLUSH_CHK: begin
        priority if (!sts_i.pend_valid) begin
          state_d = S_PUSH;
        end else if (sts_i.pend_first) begin
          state_d = S_FLUSH_OUT;
        end else begin
          state_d = S_COR_GO;
        end
      end
      S_COR_GO: begin
        cmd_o.op = palr_pkg::DP_CORDIC;
        state_d  = S_W_COR;
      end
      S_W_COR: begin
        if (sts_i.cordic_done) begin
          state_d = S_FLUSH_OUT;
        end
      end
      S_FLUSH_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = palr_pkg::DP_FLUSH_OUT;
          state_d  = last_phase_q ? S_LAST_OUT : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.op = palr_pkg::DP_PUSH;
        state_d  = S_LOOP;
      end
      S_SEG_END: begin
        cmd_o.op = palr_pkg::DP_SEG_END;
        state_d  = S_PREV;
      end
      S_PREV: begin
        cmd_o.op = palr_pkg::DP_PREV;
        state_d  = sts_i.in_last ? S_LAST_CHK : S_IDLE;
      end
      S_LAST_CHK: begin
        priority if (sts_i.arc_zero) begin
          state_d = S_DEGEN;
        end else if (sts_i.pend_valid && !sts_i.pend_match) begin
          last_phase_d = 1'b1;
          state_d      = S_FLUSH_CHK;
        end else begin
          state_d = S_LAST_OUT;
        end
      end
      S_LAST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.op = palr_pkg::DP_OUT_LAST;
          state_d  = S_IDLE;
        end
      end
      S_DEGEN: begin
        if (sts_i.out_free) begin
          cmd_o.op = palr_pkg::DP_OUT_DEGEN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      coord_q      <= palr_pkg::COORD_X;
      last_phase_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      coord_q      <= coord_d;
      last_phase_q <= last_phase_d;
    end
  end

endmodule

>>> hw/rtl/polyline_arc_length_resampler.sv
// Resamples a stream of path vertices at even planar arc-length spacing
// (sample_spacing, unsigned Q0.16 metres, zero acts as one). Each vertex beat
// first gets its segment length (two shift-add squares and a root on the
// shared multi-cycle arithmetic unit), then, per sample on the segment,
// a multiply and a divide per coordinate on that same unit and the heading
// of the sample before it (normalizing shifter, 24-step vectoring rotator).
// One vertex is worked on at a time; a finished result sits in the output
// register while the next vertex beat is taken. Interior samples come out one
// sample late, since their heading needs the sample after them; the path
// closes with the final vertex, flagged with tlast. A path that is too short,
// or a segment that needs more than 62 samples, gives one status beat instead
// (the rest of a too-long path is dropped up to its final vertex).
module polyline_arc_length_resampler (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          cfg_wr_en_i,
  input  logic [15:0]   cfg_wr_data_i,
  // vertex stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // point_x, point_y, point_z, point_heading
  input  logic          s_axis_tlast,   // last_point
  // sample stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [111:0]  m_axis_tdata,   // out_x, out_y, out_z, out_heading
  output logic          m_axis_tlast,   // last_sample
  output logic [1:0]    m_axis_tuser    // status
);

  palr_pkg::dp_cmd_t cmd;
  palr_pkg::dp_sts_t sts;
  logic [31:0]       out_x, out_y, out_z;
  logic [15:0]       out_hd;

  palr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  palr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_x_i        (s_axis_tdata[31:0]),
    .in_y_i        (s_axis_tdata[63:32]),
    .in_z_i        (s_axis_tdata[95:64]),
    .in_heading_i  (s_axis_tdata[111:96]),
    .in_last_i     (s_axis_tlast),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_z_o       (out_z),
    .out_heading_o (out_hd),
    .out_last_o    (m_axis_tlast),
    .out_status_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {out_hd, out_z, out_y, out_x};

endmodule

>>> verif/palr_checker.sv
module palr_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [15:0]   cfg_wr_data_i,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tready,
  input  logic [111:0]  s_axis_tdata,   // point_x, point_y, point_z, point_heading
  input  logic          s_axis_tlast,   // last_point
  input  logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic [111:0]  m_axis_tdata,   // out_x, out_y, out_z, out_heading
  input  logic          m_axis_tlast,   // last_sample
  input  logic [1:0]    m_axis_tuser,   // status
  output int            fail_count_o,
  output int            outstanding_o,
  output int            samples_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int                x;
    int                y;
    int                z;
    logic [15:0]       heading;
    logic              last;
    palr_pkg::status_e status;
  } sample_t;

  localparam logic [31:0] AtanLut [palr_pkg::CordicSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  sample_t     expected_samples_q [$];
  logic [15:0] spacing;
  logic        started, abandoned, hold_valid, hold_is_first;
  int          last_vx, last_vy, last_vz;
  logic [47:0] arc_pos, next_arc;
  int          hold_x, hold_y, hold_z;
  int          sent_x, sent_y;
  logic [15:0] first_hd;

  // planar segment length, floor of the square root
  function automatic logic [32:0] seg_len(longint dx, longint dy);
    logic [63:0] ax, ay;
    logic [65:0] sum, sq;
    logic [32:0] r, c;
    ax  = dx < 0 ? -dx : dx;
    ay  = dy < 0 ? -dy : dy;
    sum = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    r   = '0;
    for (int b = 32; b >= 0; b--) begin
      c  = r | (33'd1 << b);
      sq = 66'(c) * 66'(c);
      if (sq <= sum) r = c;
    end
    return r;
  endfunction

  // cordic vectoring yaw of a chord
  function automatic logic [15:0] chord_heading(longint dx, longint dy);
    logic [63:0] ax, ay;
    longint      x, y, xs, ys;
    logic [31:0] z, a;
    if (dx == 0 && dy == 0) return 16'd0;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    while ((ax > ay ? ax : ay) >= (64'd1 << 30)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    while ((ax > ay ? ax : ay) < (64'd1 << 29)) begin
      ax = ax << 1;
      ay = ay << 1;
    end
    x = longint'(ax);
    y = longint'(ay);
    z = '0;
    for (int i = 0; i < palr_pkg::CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + AtanLut[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - AtanLut[i];
      end
    end
    if (dx < 0) a = (dy < 0) ? z + 32'h80000000 : 32'h80000000 - z;
    else        a = (dy < 0) ? 32'd0 - z : z;
    a = (a + 32'h8000) >> 16;
    return a[15:0];
  endfunction

  // linear interpolation, rounded half away from zero
  function automatic int lerp(int p0, int p1, logic [63:0] s, logic [63:0] len);
    longint      d;
    logic [63:0] md, q;
    longint      r;
    d  = longint'(p1) - longint'(p0);
    md = d < 0 ? -d : d;
    q  = (64'd2 * md * s + len) / (64'd2 * len);
    r  = longint'(p0) + (d < 0 ? -longint'(q) : longint'(q));
    return int'(r);
  endfunction

  task automatic push_result(int x, int y, int z, logic [15:0] hd, logic last,
                             palr_pkg::status_e st);
    sample_t e;
    e.x = x; e.y = y; e.z = z; e.heading = hd; e.last = last; e.status = st;
    expected_samples_q.insert(expected_samples_q.size(), e);
  endtask

  task automatic release_held(int nx, int ny);
    logic [15:0] hd;
    if (!hold_valid) return;
    hd = hold_is_first ? first_hd
                       : chord_heading(longint'(nx) - longint'(sent_x),
                                       longint'(ny) - longint'(sent_y));
    push_result(hold_x, hold_y, hold_z, hd, 1'b0, palr_pkg::STATUS_OK);
    sent_x = hold_x;
    sent_y = hold_y;
  endtask

  task automatic clear_path();
    started = 0; abandoned = 0; hold_valid = 0; hold_is_first = 0;
    last_vx = 0; last_vy = 0; last_vz = 0;
    arc_pos = '0; next_arc = '0;
    hold_x = 0; hold_y = 0; hold_z = 0;
    sent_x = 0; sent_y = 0; first_hd = '0;
  endtask

  // expected samples for one vertex beat
  task automatic predict_vertex(int px, int py, int pz, logic [15:0] hd, logic last);
    logic [63:0] sp, len, off, cnt, s;
    int          ix, iy, iz;
    sp = (spacing == 0) ? 64'd1 : 64'(spacing);
    if (abandoned) begin
      if (last) clear_path();
      return;
    end
    if (!started) begin
      if (last) begin
        push_result(0, 0, 0, 16'd0, 1'b1, palr_pkg::STATUS_DEGENERATE);
        clear_path();
        return;
      end
      started = 1;
      last_vx = px; last_vy = py; last_vz = pz;
      arc_pos = '0;
      next_arc = sp[47:0];
      hold_valid = 1; hold_is_first = 1;
      hold_x = px; hold_y = py; hold_z = pz;
      first_hd = hd;
      return;
    end
    len = 64'(seg_len(longint'(px) - longint'(last_vx), longint'(py) - longint'(last_vy)));
    if (len != 0) begin
      off = 64'(48'(next_arc - arc_pos));
      cnt = (len > off) ? (len - off + sp - 64'd1) / sp : 64'd0;
      if (cnt > 64'(palr_pkg::MaxSamplesPerSeg)) begin
        push_result(0, 0, 0, 16'd0, 1'b1, palr_pkg::STATUS_TOO_LONG);
        if (last) clear_path();
        else abandoned = 1;
        return;
      end
      for (logic [63:0] k = 0; k < cnt; k++) begin
        s  = off + k * sp;
        ix = lerp(last_vx, px, s, len);
        iy = lerp(last_vy, py, s, len);
        iz = lerp(last_vz, pz, s, len);
        release_held(ix, iy);
        hold_x = ix; hold_y = iy; hold_z = iz;
        hold_valid = 1; hold_is_first = 0;
      end
      next_arc = next_arc + 48'(cnt * sp);
      arc_pos  = arc_pos + 48'(len);
    end
    last_vx = px; last_vy = py; last_vz = pz;
    if (last) begin
      if (arc_pos == 0) begin
        push_result(0, 0, 0, 16'd0, 1'b1, palr_pkg::STATUS_DEGENERATE);
      end else begin
        if (!(hold_valid && hold_x == px && hold_y == py)) release_held(px, py);
        push_result(px, py, pz, hd, 1'b1, palr_pkg::STATUS_OK);
      end
      clear_path();
    end
  endtask

  task automatic compare_sample();
    sample_t e;
    if (expected_samples_q.size() == 0) begin
      $error("unexpected sample beat: x %0d y %0d status %0d",
             $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]), m_axis_tuser);
      fail_count_o++;
      return;
    end
    e = expected_samples_q.pop_front();
    if (e.x != int'(m_axis_tdata[31:0])) begin
      $error("out_x expected %0d actual %0d", e.x, $signed(m_axis_tdata[31:0]));
      fail_count_o++;
    end
    if (e.y != int'(m_axis_tdata[63:32])) begin
      $error("out_y expected %0d actual %0d", e.y, $signed(m_axis_tdata[63:32]));
      fail_count_o++;
    end
    if (e.z != int'(m_axis_tdata[95:64])) begin
      $error("out_z expected %0d actual %0d", e.z, $signed(m_axis_tdata[95:64]));
      fail_count_o++;
    end
    if (e.heading != m_axis_tdata[111:96]) begin
      $error("out_heading expected %0h actual %0h", e.heading, m_axis_tdata[111:96]);
      fail_count_o++;
    end
    if (e.last != m_axis_tlast) begin
      $error("last_sample expected %0d actual %0d", e.last, m_axis_tlast);
      fail_count_o++;
    end
    if (e.status != m_axis_tuser) begin
      $error("status expected %0d actual %0d", e.status, m_axis_tuser);
      fail_count_o++;
    end
  endtask

  // watch config, vertex and sample beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_path();
      spacing = palr_pkg::SpacingReset;
      expected_samples_q.delete();
      fail_count_o   = 0;
      samples_seen_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        compare_sample();
        samples_seen_o++;
      end
      if (cfg_wr_en_i) spacing = cfg_wr_data_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_vertex(int'(s_axis_tdata[31:0]), int'(s_axis_tdata[63:32]),
                       int'(s_axis_tdata[95:64]), s_axis_tdata[111:96], s_axis_tlast);
    end
    outstanding_o = expected_samples_q.size();
  end

endmodule

>>> verif/polyline_arc_length_resampler_tb.sv
module polyline_arc_length_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DrainCycles = 20000;
  localparam longint      CycleLimit  = 40000000;
  localparam int          PhaseItems  = 86;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_wr_en_i = 1'b0;
  logic [15:0]   cfg_wr_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata = '0;
  logic          s_axis_tlast = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [111:0]  m_axis_tdata;
  logic          m_axis_tlast;
  logic [1:0]    m_axis_tuser;

  int          fail_count, outstanding, samples_seen;
  int          vertices_sent = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [15:0] cur_spacing = palr_pkg::SpacingReset;
  longint      cycle_count = 0;

  always #10 clk_i = ~clk_i;

  polyline_arc_length_resampler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  palr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .samples_seen_o (samples_seen)
  );

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // one vertex beat, valid held until taken
  task automatic send_vertex(int x, int y, int z, logic [15:0] hd, logic last);
    logic taken;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hd, z, y, x};
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    vertices_sent++;
  endtask

  // wait for all samples and any silent work, then write spacing
  task automatic write_spacing(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cur_spacing   = value;
  endtask

  function automatic int signed_rand(int unsigned span);
    int v;
    v = int'($urandom_range(0, span));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // random path: mostly well formed, some degenerate and noisy ones
  task automatic random_path();
    int          kind, n, x, y, z;
    int unsigned sp, span;
    sp   = (cur_spacing == 0) ? 1 : cur_spacing;
    kind = $urandom_range(0, 99);
    x = $urandom; y = $urandom; z = $urandom;
    if (kind < 8) begin
      send_vertex(x, y, z, 16'($urandom), 1'b1);
    end else if (kind < 14) begin
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) send_vertex(x, y, $urandom, 16'($urandom), i == n - 1);
    end else if (kind < 20) begin
      n = $urandom_range(2, 5);
      for (int i = 0; i < n; i++)
        send_vertex($urandom, $urandom, $urandom, 16'($urandom), $urandom_range(0, 3) == 0);
      send_vertex($urandom, $urandom, $urandom, 16'($urandom), 1'b1);
    end else begin
      n = $urandom_range(2, 7);
      send_vertex(x, y, z, 16'($urandom), 1'b0);
      for (int i = 1; i < n; i++) begin
        span = ($urandom_range(0, 99) < 3) ? 70 * sp : 3 * sp;
        if ($urandom_range(0, 9) != 0) begin
          x += signed_rand(span);
          y += signed_rand(span);
        end
        z = $urandom;
        send_vertex(x, y, z, 16'($urandom), i == n - 1);
      end
    end
  endtask

  initial begin
    logic [15:0] phase_spacing [5];
    int          phase_idle [5];
    int          phase_stall [5];
    int          phase_start;
    phase_spacing = '{16'd1, 16'd65535, 16'd3277, 16'd1000, 16'd0};
    phase_idle    = '{0, 54, 0, 23, 0};
    phase_stall   = '{0, 0, 54, 23, 0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed paths at a short spacing
    write_spacing(16'd16);
    send_vertex(7, -9, 3, 16'h7FFF, 1'b1);                    // lone vertex
    send_vertex(5, 5, 1, 16'h8000, 1'b0);                     // zero total length
    send_vertex(5, 5, 2, 16'h0001, 1'b0);
    send_vertex(5, 5, -1, 16'h1234, 1'b1);
    send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0);
    send_vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 1'b0); // too long
    send_vertex(0, 0, 0, 16'h0000, 1'b0);                     // dropped
    send_vertex(1, 1, 1, 16'h0000, 1'b1);                     // dropped, closes
    send_vertex(0, 0, 0, 16'h4000, 1'b0);                     // backtrack, zero chord
    send_vertex(32, 0, 100, 16'h0000, 1'b0);
    send_vertex(32, 0, 100, 16'h0000, 1'b0);                  // zero-length segment
    send_vertex(0, 0, -100, 16'hC000, 1'b1);
    send_vertex(0, 0, 0, 16'h1111, 1'b0);                     // final replaces held
    send_vertex(16, 0, 0, 16'h2222, 1'b0);
    send_vertex(17, 0, 0, 16'h3333, 1'b0);
    send_vertex(16, 0, 0, 16'h4444, 1'b1);
    send_vertex(0, 0, 0, 16'h5555, 1'b0);                     // final replaces first
    send_vertex(5, 0, 0, 16'h6666, 1'b0);
    send_vertex(0, 0, 0, 16'h7777, 1'b1);
    send_vertex(-100, 50, 9, 16'h0100, 1'b0);                 // spacing change mid path
    write_spacing(16'd0);
    send_vertex(-97, 54, 9, 16'h0200, 1'b0);
    send_vertex(-90, 60, 19, 16'h0300, 1'b1);

    // random phases over spacing and idling patterns
    for (int p = 0; p < 5; p++) begin
      write_spacing(phase_spacing[p]);
      sender_idle_pct = phase_idle[p];
      recv_stall_pct  = phase_stall[p];
      phase_start     = vertices_sent;
      while (vertices_sent - phase_start < PhaseItems) random_path();
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d vertex beats and %0d sample beats over six spacings,",
             vertices_sent, samples_seen);
    $display("with degenerate, too-long and noisy paths under mixed idling");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> polyline_arc_length_resampler.f
hw/rtl/palr_pkg.sv
hw/rtl/palr_arith.sv
hw/rtl/palr_cordic.sv
hw/rtl/palr_datapath.sv
hw/rtl/palr_ctrl.sv
hw/rtl/polyline_arc_length_resampler.sv
verif/palr_checker.sv
verif/polyline_arc_length_resampler_tb.sv
